>>> rtl/tzrp_pkg.sv
// ============================================================================
// tzrp_pkg: shared definitions for the time zone rule parser
// Widths, parse phase codes, character constants and the small helper
// functions used by the parser datapath and its interfaces.
// ============================================================================
package tzrp_pkg;

    localparam int CHAR_W   = 8;
    localparam int OFFSET_W = 14;
    localparam int FIELD_W  = 8;
    localparam int NFIELDS  = 8;

    localparam logic [2:0] PH_STD   = 3'd0;
    localparam logic [2:0] PH_OFF   = 3'd1;
    localparam logic [2:0] PH_DLN   = 3'd2;
    localparam logic [2:0] PH_START = 3'd3;
    localparam logic [2:0] PH_END   = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    localparam logic [2:0] SP_LEAD = 3'd0;
    localparam logic [2:0] SP_MON  = 3'd1;
    localparam logic [2:0] SP_WEEK = 3'd2;
    localparam logic [2:0] SP_WDAY = 3'd3;
    localparam logic [2:0] SP_HOUR = 3'd4;
    localparam logic [2:0] SP_STOP = 3'd5;

    localparam logic [1:0] FI_MONTH   = 2'd0;
    localparam logic [1:0] FI_WEEK    = 2'd1;
    localparam logic [1:0] FI_WEEKDAY = 2'd2;
    localparam logic [1:0] FI_HOUR    = 2'd3;

    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [7:0] DEFAULT_HOUR = 8'd2;
    localparam logic [12:0] MIN_PER_HOUR = 13'd60;

    typedef struct packed {
        logic [2:0] sub;
        logic       acc;
        logic       clr;
        logic [1:0] idx;
    } t_param_step;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] mul10_add(input logic [7:0] v, input logic [3:0] d);
        return 8'({v[4:0], 3'b000} + {v[6:0], 1'b0} + {4'b0000, d});
    endfunction

    function automatic t_param_step param_step(input logic [2:0] sub, input logic [7:0] c);
        t_param_step r;
        logic        dn;
        logic        dg;
        r   = '{sub: sub, acc: 1'b0, clr: 1'b0, idx: FI_MONTH};
        dn  = 1'b0;
        dg  = is_decimal(c);
        if (r.sub == SP_LEAD) begin
            r.sub = SP_MON;
            if (c == CH_M) dn = 1'b1;
        end
        if (!dn && r.sub == SP_MON) begin
            dn = 1'b1;
            if (dg) begin
                r.acc = 1'b1;
                r.idx = FI_MONTH;
            end else begin
                r.sub = SP_WEEK;
                dn    = (c == CH_DOT);
            end
        end
        if (!dn && r.sub == SP_WEEK) begin
            dn = 1'b1;
            if (dg) begin
                r.acc = 1'b1;
                r.idx = FI_WEEK;
            end else begin
                r.sub = SP_WDAY;
                dn    = (c == CH_DOT);
            end
        end
        if (!dn && r.sub == SP_WDAY) begin
            dn = 1'b1;
            if (dg) begin
                r.acc = 1'b1;
                r.idx = FI_WEEKDAY;
            end else if (c == CH_SLASH) begin
                r.clr = 1'b1;
                r.idx = FI_HOUR;
                r.sub = SP_HOUR;
            end else begin
                r.sub = SP_STOP;
            end
        end
        if (!dn && r.sub == SP_HOUR) begin
            dn = 1'b1;
            if (dg) begin
                r.acc = 1'b1;
                r.idx = FI_HOUR;
            end else begin
                r.sub = SP_STOP;
            end
        end
        if (!dn) begin
            r.sub = SP_STOP;
        end
        return r;
    endfunction

endpackage

>>> rtl/tzrp_if.sv
// ============================================================================
// tzrp_if: stream interfaces of the time zone rule parser
// One interface for the character stream and one for the parse results.
// ============================================================================
interface tzrp_in_if import tzrp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface tzrp_out_if import tzrp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic signed [OFFSET_W-1:0] std_offset_min;
    logic signed [OFFSET_W-1:0] dst_offset_min;
    logic                       has_dst;
    logic [FIELD_W-1:0]         start_month;
    logic [FIELD_W-1:0]         start_week;
    logic [FIELD_W-1:0]         start_weekday;
    logic [FIELD_W-1:0]         start_hour;
    logic [FIELD_W-1:0]         end_month;
    logic [FIELD_W-1:0]         end_week;
    logic [FIELD_W-1:0]         end_weekday;
    logic [FIELD_W-1:0]         end_hour;

    modport source (
        output valid, output status, output std_offset_min, output dst_offset_min,
        output has_dst, output start_month, output start_week, output start_weekday,
        output start_hour, output end_month, output end_week, output end_weekday,
        output end_hour, input ready
    );
    modport sink (
        input valid, input status, input std_offset_min, input dst_offset_min,
        input has_dst, input start_month, input start_week, input start_weekday,
        input start_hour, input end_month, input end_week, input end_weekday,
        input end_hour, output ready
    );
endinterface

>>> rtl/posix_tz_rule_parser.sv
// ============================================================================
// posix_tz_rule_parser: POSIX-style time zone rule parser
// Parses a zone rule one character per transaction and emits the offsets
// and the daylight transition parameters on the last character.
// ============================================================================
//  Channel  Direction  Payload                              Transaction
//  i_in     sink       char_code, is_last                   one rule character
//  o_out    source     status, offsets, has_dst, 8 fields   one parsed rule
//
//  One character is taken per cycle while i_in.ready is high; the parse state updates in that cycle.
//  The result of a rule is registered and shows in the cycle after its last
//  character. The output register decouples the sides: i_in.ready is low
//  only while a result is held and o_out.ready is low. A synchronous reset
//  returns the parser to the start of a rule and drops any pending result.
module posix_tz_rule_parser import tzrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tzrp_in_if.sink     i_in,
    tzrp_out_if.source  o_out
);

    logic [2:0]         r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [6:0]         r_hour, n_hour;
    logic [1:0]         r_hcnt, n_hcnt;
    logic [6:0]         r_min, n_min;
    logic [1:0]         r_mcnt, n_mcnt;
    logic               r_dst_seen, n_dst_seen;
    logic [2:0]         r_sub, n_sub;
    logic [FIELD_W-1:0] r_fields [NFIELDS];
    logic [FIELD_W-1:0] n_fields [NFIELDS];
    logic               r_error, n_error;

    logic                       r_out_valid;
    logic                       r_status;
    logic signed [OFFSET_W-1:0] r_std;
    logic signed [OFFSET_W-1:0] r_dst;
    logic                       r_has_dst;
    logic [FIELD_W-1:0]         r_ofields [NFIELDS];

    logic        w_fire;
    logic [7:0]  w_c;
    logic        w_letter, w_digit, w_comma;
    logic [3:0]  w_dval;
    logic        w_go_off, w_in_off, w_go_dln, w_in_dln;
    logic        w_hi;
    t_param_step w_ps;
    logic        w_err;
    logic [12:0] w_mag;
    logic signed [OFFSET_W-1:0] w_std, w_dst;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_fire     = i_in.valid && i_in.ready;

    assign w_c      = i_in.char_code;
    assign w_letter = is_letter(w_c);
    assign w_digit  = is_decimal(w_c);
    assign w_comma  = (w_c == CH_COMMA);
    assign w_dval   = w_c[3:0];
    assign w_go_off = (r_phase == PH_STD) && !w_letter;
    assign w_in_off = (r_phase == PH_OFF) || w_go_off;
    assign w_go_dln = w_in_off && (w_letter || w_comma);
    assign w_in_dln = (r_phase == PH_DLN) || w_go_dln;
    assign w_hi     = (r_phase == PH_END);
    assign w_ps     = param_step(r_sub, w_c);

    always_comb begin
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_hour     = r_hour;
        n_hcnt     = r_hcnt;
        n_min      = r_min;
        n_mcnt     = r_mcnt;
        n_dst_seen = r_dst_seen;
        n_sub      = r_sub;
        n_error    = r_error;
        for (int j = 0; j < NFIELDS; j++) begin
            n_fields[j] = r_fields[j];
        end

        if (w_go_off) begin
            n_phase = PH_OFF;
        end
        if (w_in_off && !w_go_dln) begin
            if (r_sub == SP_LEAD) begin
                if (w_c == CH_MINUS && r_hcnt == 2'd0) begin
                    n_neg = 1'b1;
                end else if (w_digit && r_hcnt < 2'd2) begin
                    n_hour = 7'(r_hour * 7'd10 + {3'b000, w_dval});
                    n_hcnt = r_hcnt + 2'd1;
                end else if (w_c == CH_COLON && r_hcnt != 2'd0) begin
                    n_sub = SP_MON;
                end
            end else if (w_digit && r_mcnt < 2'd2) begin
                n_min  = 7'(r_min * 7'd10 + {3'b000, w_dval});
                n_mcnt = r_mcnt + 2'd1;
            end
        end

        if (w_in_dln) begin
            if (w_go_dln) n_sub = SP_LEAD;
            priority if (w_letter) begin
                n_phase    = PH_DLN;
                n_dst_seen = 1'b1;
            end else if (w_comma) begin
                n_phase = PH_START;
                n_sub   = SP_LEAD;
            end else begin
                n_phase = PH_DONE;
                n_error = 1'b1;
            end
        end else if ((r_phase == PH_START && !w_comma) || r_phase == PH_END) begin
            n_sub = w_ps.sub;
            for (int j = 0; j < NFIELDS; j++) begin
                if (3'(j) == {w_hi, w_ps.idx}) begin
                    if (w_ps.acc) n_fields[j] = mul10_add(r_fields[j], w_dval);
                    else if (w_ps.clr) n_fields[j] = '0;
                end
            end
        end else if (r_phase == PH_START) begin
            n_phase = PH_END;
            n_sub   = SP_LEAD;
        end
    end

    assign w_err = n_error || (n_phase == PH_DLN) || (n_phase == PH_START)
                   || (n_phase == PH_DONE);
    assign w_mag = 13'(13'(n_hour) * MIN_PER_HOUR) + 13'(n_min);
    assign w_std = n_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    assign w_dst = n_dst_seen ? OFFSET_W'(w_std - 14'sd60) : w_std;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_fire && i_in.is_last)) begin
            r_phase    <= PH_STD;
            r_neg      <= 1'b0;
            r_hour     <= '0;
            r_hcnt     <= '0;
            r_min      <= '0;
            r_mcnt     <= '0;
            r_dst_seen <= 1'b0;
            r_sub      <= SP_LEAD;
            r_error    <= 1'b0;
            for (int j = 0; j < NFIELDS; j++) begin
                r_fields[j] <= (2'(j) == FI_HOUR) ? DEFAULT_HOUR : '0;
            end
        end else if (w_fire) begin
            r_phase    <= n_phase;
            r_neg      <= n_neg;
            r_hour     <= n_hour;
            r_hcnt     <= n_hcnt;
            r_min      <= n_min;
            r_mcnt     <= n_mcnt;
            r_dst_seen <= n_dst_seen;
            r_sub      <= n_sub;
            r_error    <= n_error;
            for (int j = 0; j < NFIELDS; j++) begin
                r_fields[j] <= n_fields[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && i_in.is_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && i_in.is_last) begin
            r_status  <= w_err;
            r_std     <= w_err ? '0 : w_std;
            r_dst     <= w_err ? '0 : w_dst;
            r_has_dst <= !w_err && n_dst_seen;
            for (int j = 0; j < NFIELDS; j++) begin
                r_ofields[j] <= (!w_err && n_phase == PH_END) ? n_fields[j] : '0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_status;
    assign o_out.std_offset_min = r_std;
    assign o_out.dst_offset_min = r_dst;
    assign o_out.has_dst        = r_has_dst;
    assign o_out.start_month    = r_ofields[0];
    assign o_out.start_week     = r_ofields[1];
    assign o_out.start_weekday  = r_ofields[2];
    assign o_out.start_hour     = r_ofields[3];
    assign o_out.end_month      = r_ofields[4];
    assign o_out.end_week       = r_ofields[5];
    assign o_out.end_weekday    = r_ofields[6];
    assign o_out.end_hour       = r_ofields[7];

endmodule

>>> rtl/tzrp_checker.sv
// ============================================================================
// tzrp_checker: port-level checks for the time zone rule parser
// Watches the stream ports of the parser and is bound to its top level.
// ============================================================================
module tzrp_checker import tzrp_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_in_is_last,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_out_status,
    input logic signed [OFFSET_W-1:0] i_out_std,
    input logic signed [OFFSET_W-1:0] i_out_dst,
    input logic                       i_out_has_dst,
    input logic [FIELD_W-1:0]         i_out_start_month,
    input logic [FIELD_W-1:0]         i_out_end_hour
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result transaction dropped while stalled.");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_is_last |=> i_out_valid)
        else $error("No result after the last character of a rule.");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_is_last |=> !i_out_valid)
        else $error("Result appeared without a last character.");

    a_error_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status |-> (i_out_std == '0) && (i_out_dst == '0)
            && !i_out_has_dst && (i_out_start_month == '0) && (i_out_end_hour == '0))
        else $error("Error result carries nonzero fields.");

endmodule

bind posix_tz_rule_parser tzrp_checker u_tzrp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_is_last      (i_in.is_last),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_status      (o_out.status),
    .i_out_std         (o_out.std_offset_min),
    .i_out_dst         (o_out.dst_offset_min),
    .i_out_has_dst     (o_out.has_dst),
    .i_out_start_month (o_out.start_month),
    .i_out_end_hour    (o_out.end_hour)
);
